FILE: rtl/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types and constants of the dark-run corner finder: pixel and result
// payloads, configuration register indexes and the window geometry.
// ----------------------------------------------------------------------------
package drc_pkg;

    localparam int WINDOW_LEN = 50;
    localparam int SLOT_W     = $clog2(WINDOW_LEN);
    localparam int PIX_W      = 8;
    localparam int PSUM_W     = 10;
    localparam int WSUM_W     = 16;
    localparam int DIM_W      = 11;
    localparam int CORNER_W   = 12;
    localparam int CFG_W      = 16;
    localparam int IDX_W      = 2;

    localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);
    localparam logic [PIX_W-1:0]    PAINT_RED = 8'd214;
    localparam logic [CORNER_W-1:0] NO_TOP    = 12'd1000;
    localparam logic [CORNER_W-1:0] NO_BOTTOM = '1;

    localparam logic [DIM_W-1:0]  RESET_WIDTH     = 11'd1280;
    localparam logic [DIM_W-1:0]  RESET_HEIGHT    = 11'd720;
    localparam logic [WSUM_W-1:0] RESET_THRESHOLD = 16'd12000;
    localparam logic [DIM_W-1:0]  RESET_CUTOFF    = 11'd1043;

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_DARK_THRESHOLD = 2'd2,
        REG_COLUMN_CUTOFF  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0]           out_red;
        logic [PIX_W-1:0]           out_green;
        logic [PIX_W-1:0]           out_blue;
        logic [DIM_W-1:0]           top_row;
        logic signed [CORNER_W-1:0] top_col;
        logic signed [CORNER_W-1:0] bottom_row;
        logic signed [CORNER_W-1:0] bottom_col;
        logic                       frame_end;
    } result_t;

    typedef struct packed {
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [WSUM_W-1:0] dark_threshold;
        logic [DIM_W-1:0]  column_cutoff;
    } cfg_t;

    typedef struct packed {
        logic              push;
        logic              clear;
        logic [PSUM_W-1:0] value;
    } win_ctl_t;

    typedef struct packed {
        logic              full;
        logic [WSUM_W-1:0] sum;
    } win_stat_t;

endpackage

FILE: rtl/drc_ram.sv
// ----------------------------------------------------------------------------
// drc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module drc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/drc_window.sv
// ----------------------------------------------------------------------------
// drc_window
// Sliding window of pixel sums: ring buffer in RAM, write slot, fill flag
// and running sum. The entry about to be overwritten is prefetched.
// ----------------------------------------------------------------------------
module drc_window (
    input  logic              clk,
    input  logic              rst_n,
    input  drc_pkg::win_ctl_t ctl,
    output drc_pkg::win_stat_t stat
);

    logic [drc_pkg::SLOT_W-1:0] slot_reg;
    logic [drc_pkg::SLOT_W-1:0] slot_next;
    logic [drc_pkg::SLOT_W-1:0] slot_inc;
    logic [drc_pkg::SLOT_W-1:0] raddr;
    logic                       full_reg;
    logic                       full_next;
    logic [drc_pkg::WSUM_W-1:0] sum_reg;
    logic [drc_pkg::WSUM_W-1:0] sum_next;
    logic [drc_pkg::PSUM_W-1:0] old_value;
    logic [drc_pkg::WSUM_W-1:0] sum_upd;
    logic                       full_upd;

    assign slot_inc = (slot_reg == drc_pkg::LAST_SLOT) ? '0 : slot_reg + 1'b1;

    // old entry is dropped only once the window is full
    assign sum_upd = sum_reg
                   - (full_reg ? drc_pkg::WSUM_W'(old_value) : '0)
                   + drc_pkg::WSUM_W'(ctl.value);
    assign full_upd = full_reg | (slot_inc == drc_pkg::LAST_SLOT);

    always_comb
    begin
        slot_next = slot_reg;
        full_next = full_reg;
        sum_next  = sum_reg;
        priority if (ctl.clear)
        begin
            slot_next = drc_pkg::LAST_SLOT;
            full_next = 1'b0;
            sum_next  = '0;
        end
        else if (ctl.push)
        begin
            slot_next = slot_inc;
            full_next = full_upd;
            sum_next  = sum_upd;
        end
    end

    // prefetch the slot the next push will overwrite
    assign raddr = (slot_next == drc_pkg::LAST_SLOT) ? '0 : slot_next + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= drc_pkg::LAST_SLOT;
            full_reg <= 1'b0;
            sum_reg  <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            full_reg <= full_next;
            sum_reg  <= sum_next;
        end
    end

    drc_ram #(
        .WIDTH (drc_pkg::PSUM_W),
        .DEPTH (drc_pkg::WINDOW_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ctl.push),
        .waddr (slot_inc),
        .wdata (ctl.value),
        .raddr (raddr),
        .rdata (old_value)
    );

    assign stat.full = full_upd;
    assign stat.sum  = sum_upd;

endmodule

FILE: rtl/drc_tracker.sv
// ----------------------------------------------------------------------------
// drc_tracker
// Raster position, half flag and corner tracking; forms the result for the
// pixel in the input register.
// ----------------------------------------------------------------------------
module drc_tracker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  drc_pkg::cfg_t              cfg,
    input  logic                       step,
    input  drc_pkg::pixel_t            pix,
    input  logic [drc_pkg::PSUM_W-1:0] pix_sum,
    input  drc_pkg::win_stat_t         win_stat,
    output drc_pkg::win_ctl_t          win_ctl,
    output drc_pkg::result_t           result
);

    logic [drc_pkg::DIM_W-1:0]    row_reg, row_next;
    logic [drc_pkg::DIM_W-1:0]    col_reg, col_next;
    logic                         half_reg, half_next;
    logic [drc_pkg::CORNER_W-1:0] top_row_reg, top_row_next;
    logic [drc_pkg::CORNER_W-1:0] top_col_reg, top_col_next;
    logic [drc_pkg::CORNER_W-1:0] bot_row_reg, bot_row_next;
    logic [drc_pkg::CORNER_W-1:0] bot_col_reg, bot_col_next;

    logic                         cut;
    logic                         half_upd;
    logic                         dark;
    logic signed [drc_pkg::CORNER_W:0] pos;
    logic signed [drc_pkg::CORNER_W:0] top_pos;
    logic signed [drc_pkg::CORNER_W:0] bot_pos;
    logic                         top_hit;
    logic                         bot_hit;
    logic [drc_pkg::CORNER_W-1:0] top_row_upd, top_col_upd;
    logic [drc_pkg::CORNER_W-1:0] bot_row_upd, bot_col_upd;
    logic                         row_end;
    logic                         last;

    assign cut = (col_reg >= cfg.column_cutoff);

    assign half_upd = half_reg | (row_reg > (cfg.frame_height >> 1));
    assign dark     = win_stat.full && (win_stat.sum < cfg.dark_threshold);

    assign pos     = $signed({2'b00, row_reg} + {2'b00, col_reg});
    assign top_pos = $signed({top_row_reg[drc_pkg::CORNER_W-1], top_row_reg})
                   + $signed({top_col_reg[drc_pkg::CORNER_W-1], top_col_reg});
    assign bot_pos = $signed({bot_row_reg[drc_pkg::CORNER_W-1], bot_row_reg})
                   + $signed({bot_col_reg[drc_pkg::CORNER_W-1], bot_col_reg});

    assign top_hit = !cut && dark && !half_upd && (top_pos > pos);
    assign bot_hit = !cut && dark && half_upd && (bot_pos < pos);

    assign top_row_upd = top_hit ? {1'b0, row_reg} : top_row_reg;
    assign top_col_upd = top_hit ? ({1'b0, col_reg} - drc_pkg::CORNER_W'(drc_pkg::WINDOW_LEN))
                                 : top_col_reg;
    assign bot_row_upd = bot_hit ? {1'b0, row_reg} : bot_row_reg;
    assign bot_col_upd = bot_hit ? {1'b0, col_reg} : bot_col_reg;

    assign row_end = ({1'b0, col_reg} + 1'b1) >= {1'b0, cfg.frame_width};
    assign last    = row_end && (({1'b0, row_reg} + 1'b1) >= {1'b0, cfg.frame_height});

    assign win_ctl.push  = step && !cut;
    assign win_ctl.clear = step && last;
    assign win_ctl.value = pix_sum;

    always_comb
    begin
        result.out_red    = cut ? drc_pkg::PAINT_RED : pix.red;
        result.out_green  = cut ? '0 : pix.green;
        result.out_blue   = cut ? '0 : pix.blue;
        result.top_row    = top_row_upd[drc_pkg::DIM_W-1:0];
        result.top_col    = $signed(top_col_upd);
        result.bottom_row = $signed(bot_row_upd);
        result.bottom_col = $signed(bot_col_upd);
        result.frame_end  = last;
    end

    always_comb
    begin
        row_next     = row_reg;
        col_next     = col_reg;
        half_next    = half_reg;
        top_row_next = top_row_reg;
        top_col_next = top_col_reg;
        bot_row_next = bot_row_reg;
        bot_col_next = bot_col_reg;
        if (step)
        begin
            priority if (last)
            begin
                row_next     = '0;
                col_next     = '0;
                half_next    = 1'b0;
                top_row_next = drc_pkg::NO_TOP;
                top_col_next = drc_pkg::NO_TOP;
                bot_row_next = drc_pkg::NO_BOTTOM;
                bot_col_next = drc_pkg::NO_BOTTOM;
            end
            else
            begin
                if (row_end)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
                half_next    = cut ? half_reg : half_upd;
                top_row_next = top_row_upd;
                top_col_next = top_col_upd;
                bot_row_next = bot_row_upd;
                bot_col_next = bot_col_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            half_reg    <= 1'b0;
            top_row_reg <= drc_pkg::NO_TOP;
            top_col_reg <= drc_pkg::NO_TOP;
            bot_row_reg <= drc_pkg::NO_BOTTOM;
            bot_col_reg <= drc_pkg::NO_BOTTOM;
        end
        else
        begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            half_reg    <= half_next;
            top_row_reg <= top_row_next;
            top_col_reg <= top_col_next;
            bot_row_reg <= bot_row_next;
            bot_col_reg <= bot_col_next;
        end
    end

endmodule

FILE: rtl/dark_run_corner_finder.sv
// ----------------------------------------------------------------------------
// dark_run_corner_finder
// Finds the top-left and bottom-right ends of dark pixel runs in a raster
// frame; pixels at or beyond a column cutoff are painted red.
//
//   channel | signals                          | transfer when
//   --------+----------------------------------+---------------------------
//   pixel   | pix_valid, pix_ready, pix        | pix_valid && pix_ready
//   result  | res_valid, res_ready, res        | res_valid && res_ready
//   config  | cfg_write, cfg_index, cfg_data   | cfg_write
//
// One pixel per clock sustained while results are taken; the pixel transfer
// loads the input register, and the result register loads from it when the
// pipeline advances, which a stalled result can hold off.
// The window RAM read is prefetched, so the running-sum update and corner
// compare fit between the two registers.
// A stalled result holds the result register; the input register still
// takes one more pixel. Reset clears control state and loads the register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dark_run_corner_finder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pix_valid,
    output logic                        pix_ready,
    input  drc_pkg::pixel_t             pix,
    output logic                        res_valid,
    input  logic                        res_ready,
    output drc_pkg::result_t            res,
    input  logic                        cfg_write,
    input  logic [drc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [drc_pkg::CFG_W-1:0]   cfg_data
);

    drc_pkg::cfg_t              cfg_reg;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    drc_pkg::pixel_t            s1_pix_reg;
    logic [drc_pkg::PSUM_W-1:0] s1_sum_reg;
    logic                       res_valid_reg;
    logic                       res_valid_next;
    drc_pkg::result_t           res_reg;
    logic                       advance;
    logic                       take;
    drc_pkg::win_ctl_t          win_ctl;
    drc_pkg::win_stat_t         win_stat;
    drc_pkg::result_t           result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width    <= drc_pkg::RESET_WIDTH;
            cfg_reg.frame_height   <= drc_pkg::RESET_HEIGHT;
            cfg_reg.dark_threshold <= drc_pkg::RESET_THRESHOLD;
            cfg_reg.column_cutoff  <= drc_pkg::RESET_CUTOFF;
        end
        else if (cfg_write)
        begin
            unique case (drc_pkg::cfg_idx_t'(cfg_index))
                drc_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width <= cfg_data[drc_pkg::DIM_W-1:0];
                drc_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= cfg_data[drc_pkg::DIM_W-1:0];
                drc_pkg::REG_DARK_THRESHOLD:
                    cfg_reg.dark_threshold <= cfg_data[drc_pkg::WSUM_W-1:0];
                drc_pkg::REG_COLUMN_CUTOFF:
                    cfg_reg.column_cutoff <= cfg_data[drc_pkg::DIM_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign advance   = s1_valid_reg && (!res_valid_reg || res_ready);
    assign pix_ready = !s1_valid_reg || advance;
    assign take      = pix_valid && pix_ready;

    assign s1_valid_next  = take || (s1_valid_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_pix_reg <= pix;
            s1_sum_reg <= drc_pkg::PSUM_W'({2'b00, pix.red})
                        + drc_pkg::PSUM_W'({2'b00, pix.green})
                        + drc_pkg::PSUM_W'({2'b00, pix.blue});
        end
        if (advance)
        begin
            res_reg <= result;
        end
    end

    drc_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (win_ctl),
        .stat  (win_stat)
    );

    drc_tracker u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .step     (advance),
        .pix      (s1_pix_reg),
        .pix_sum  (s1_sum_reg),
        .win_stat (win_stat),
        .win_ctl  (win_ctl),
        .result   (result)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_advance_fills_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg
    ) else $error("result register not loaded after advance");

    a_input_held_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_pix_reg))
    ) else $error("input register lost a stalled pixel");

    a_bottom_corner_pair: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.bottom_row == drc_pkg::NO_BOTTOM))
            |-> (res_reg.bottom_col == drc_pkg::NO_BOTTOM)
    ) else $error("bottom corner half set");
`endif

endmodule

FILE: verif/dark_run_corner_finder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dark_run_corner_finder_tb
// Streams pixels into the corner finder and checks every result against a
// cycle-free model of the window, raster position and corner tracking. A
// short directed opening covers the field extremes, zero frame sizes, the
// cutoff and a size change mid-frame. Random phases of dark and bright runs
// follow under several register settings, with random idling on both sides
// and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module dark_run_corner_finder_tb;

    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1950;
    localparam int LAST_PHASE_ITEMS = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_ready;
    drc_pkg::pixel_t pix = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    drc_pkg::result_t res;
    logic cfg_write = 1'b0;
    logic [drc_pkg::IDX_W-1:0] cfg_index = drc_pkg::REG_FRAME_WIDTH;
    logic [drc_pkg::CFG_W-1:0] cfg_data = '0;

    dark_run_corner_finder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    drc_pkg::pixel_t pixels_to_send[$];
    drc_pkg::result_t results_due[$];
    int pixels_queued = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int frames_closed = 0;
    int top_hits = 0;
    int bottom_hits = 0;
    int send_gap = 0;
    int sink_gap = 0;
    int receiver_hold = 0;
    bit pixel_taken = 1'b0;
    bit idling_on = 1'b1;

    // model state
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned thresh_reg;
    int unsigned cutoff_reg;
    logic [drc_pkg::PSUM_W-1:0] win_mem [drc_pkg::WINDOW_LEN];
    int unsigned win_slot;
    bit win_full;
    int unsigned win_sum;
    int unsigned row_pos;
    int unsigned col_pos;
    bit in_lower;
    int top_r;
    int top_c;
    int bot_r;
    int bot_c;

    function automatic void restart_frame();
        win_slot = drc_pkg::WINDOW_LEN - 1;
        win_full = 1'b0;
        win_sum = 0;
        row_pos = 0;
        col_pos = 0;
        in_lower = 1'b0;
        top_r = 1000;
        top_c = 1000;
        bot_r = -1;
        bot_c = -1;
    endfunction

    function automatic drc_pkg::result_t trace_pixel(input drc_pkg::pixel_t p);
        drc_pkg::result_t r;
        int unsigned psum;
        int pos;
        bit row_end;
        bit last;
        r.out_red = p.red;
        r.out_green = p.green;
        r.out_blue = p.blue;
        if (col_pos >= cutoff_reg)
        begin
            r.out_red = drc_pkg::PAINT_RED;
            r.out_green = '0;
            r.out_blue = '0;
        end
        else
        begin
            pos = int'(row_pos) + int'(col_pos);
            psum = p.red + p.green + p.blue;
            win_slot = (win_slot + 1 >= drc_pkg::WINDOW_LEN) ? 0 : win_slot + 1;
            if (win_full)
                win_sum = (win_sum - win_mem[win_slot]) & 32'hFFFF;
            win_mem[win_slot] = psum[drc_pkg::PSUM_W-1:0];
            win_sum = (win_sum + psum) & 32'hFFFF;
            if (win_slot == drc_pkg::WINDOW_LEN - 1)
                win_full = 1'b1;
            if (row_pos > height_reg / 2)
                in_lower = 1'b1;
            if (win_full && win_sum < thresh_reg)
            begin
                if (!in_lower)
                begin
                    if (top_r + top_c > pos)
                    begin
                        top_r = int'(row_pos);
                        top_c = int'(col_pos) - drc_pkg::WINDOW_LEN;
                    end
                end
                else if (bot_r + bot_c < pos)
                begin
                    bot_r = int'(row_pos);
                    bot_c = int'(col_pos);
                end
            end
        end
        row_end = (col_pos + 1 >= width_reg);
        last = row_end && (row_pos + 1 >= height_reg);
        r.top_row = top_r[drc_pkg::DIM_W-1:0];
        r.top_col = top_c[drc_pkg::CORNER_W-1:0];
        r.bottom_row = bot_r[drc_pkg::CORNER_W-1:0];
        r.bottom_col = bot_c[drc_pkg::CORNER_W-1:0];
        r.frame_end = last;
        if (last)
            restart_frame();
        else if (row_end)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1) & 32'h7FF;
        end
        else
            col_pos = (col_pos + 1) & 32'h7FF;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // monitor: pixel and result transfers
    always @(posedge clk)
    begin : port_monitor
        drc_pkg::result_t want;
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (res_valid && res_ready)
            begin
                moved = 1'b1;
                if (results_due.size() == 0)
                    report_mismatch("result with no pixel waiting for it");
                else
                begin
                    want = results_due.pop_front();
                    check_field("out_red", res.out_red, want.out_red);
                    check_field("out_green", res.out_green, want.out_green);
                    check_field("out_blue", res.out_blue, want.out_blue);
                    check_field("top_row", res.top_row, want.top_row);
                    check_field("top_col", res.top_col, want.top_col);
                    check_field("bottom_row", res.bottom_row, want.bottom_row);
                    check_field("bottom_col", res.bottom_col, want.bottom_col);
                    check_field("frame_end", res.frame_end, want.frame_end);
                    frames_closed += want.frame_end;
                    top_hits += (want.top_row != drc_pkg::NO_TOP);
                    bottom_hits += (want.bottom_row != drc_pkg::NO_BOTTOM);
                end
                results_seen++;
            end
            if (pix_valid && pix_ready)
            begin
                moved = 1'b1;
                results_due.push_back(trace_pixel(pix));
                pixel_taken = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // driver: pixel channel
    always @(negedge clk)
    begin
        if (rst_n && (!pix_valid || pixel_taken))
        begin
            pixel_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                pix_valid <= 1'b0;
            end
            else if (idling_on && pixels_to_send.size() != 0 && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(0, 6);
                pix_valid <= 1'b0;
            end
            else if (pixels_to_send.size() != 0)
            begin
                pix <= pixels_to_send.pop_front();
                pix_valid <= 1'b1;
            end
            else
                pix_valid <= 1'b0;
        end
    end

    // result side stalls
    always @(negedge clk)
    begin
        if (receiver_hold > 0)
        begin
            receiver_hold--;
            res_ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            res_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 9) == 0)
        begin
            sink_gap = $urandom_range(0, 6);
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    task automatic queue_pixel(input drc_pkg::pixel_t p);
        pixels_to_send.push_back(p);
        pixels_queued++;
    endtask

    task automatic drain();
        while (results_seen < pixels_queued)
            @(posedge clk);
    endtask

    task automatic write_reg(input drc_pkg::cfg_idx_t idx,
                             input logic [drc_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            drc_pkg::REG_FRAME_WIDTH:    width_reg = value[drc_pkg::DIM_W-1:0];
            drc_pkg::REG_FRAME_HEIGHT:   height_reg = value[drc_pkg::DIM_W-1:0];
            drc_pkg::REG_DARK_THRESHOLD: thresh_reg = value;
            drc_pkg::REG_COLUMN_CUTOFF:  cutoff_reg = value[drc_pkg::DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input int w, input int h, input int thr, input int cut);
        drain();
        write_reg(drc_pkg::REG_FRAME_WIDTH, drc_pkg::CFG_W'(w));
        write_reg(drc_pkg::REG_FRAME_HEIGHT, drc_pkg::CFG_W'(h));
        write_reg(drc_pkg::REG_DARK_THRESHOLD, drc_pkg::CFG_W'(thr));
        write_reg(drc_pkg::REG_COLUMN_CUTOFF, drc_pkg::CFG_W'(cut));
    endtask

    // random dark and bright runs with a little noise
    task automatic run_phase(input int w, input int h, input int thr, input int cut,
                             input int count, input int hold);
        drc_pkg::pixel_t p;
        bit dark;
        int seg_left;
        dark = $urandom_range(0, 1);
        seg_left = 0;
        set_frame(w, h, thr, cut);
        receiver_hold = hold;
        for (int i = 0; i < count; i++)
        begin
            if (seg_left == 0)
            begin
                dark = ($urandom_range(0, 9) < 6);
                seg_left = $urandom_range(5, 90);
            end
            seg_left--;
            if ($urandom_range(0, 19) == 0)
                p = drc_pkg::pixel_t'(24'($urandom));
            else if (dark)
                p = '{8'($urandom_range(0, 60)), 8'($urandom_range(0, 60)),
                      8'($urandom_range(0, 60))};
            else
                p = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255))};
            queue_pixel(p);
        end
    endtask

    initial
    begin : watchdog
        wait (rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("no transfer for %0d cycles", QUIET_LIMIT);
        $display("** dark_run_corner_finder: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int w;
        int thr;
        int cut;
        width_reg = drc_pkg::RESET_WIDTH;
        height_reg = drc_pkg::RESET_HEIGHT;
        thresh_reg = drc_pkg::RESET_THRESHOLD;
        cutoff_reg = drc_pkg::RESET_CUTOFF;
        restart_frame();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // field extremes under the reset settings
        queue_pixel('{8'h00, 8'h00, 8'h00});
        queue_pixel('{8'hFF, 8'hFF, 8'hFF});
        queue_pixel('{8'hFF, 8'h00, 8'h00});
        queue_pixel('{8'h00, 8'hFF, 8'h00});
        queue_pixel('{8'h00, 8'h00, 8'hFF});
        queue_pixel('{8'hAA, 8'h55, 8'hAA});
        queue_pixel('{8'h55, 8'hAA, 8'h55});

        // zero frame size: every pixel closes a frame
        set_frame(0, 0, drc_pkg::RESET_THRESHOLD, drc_pkg::RESET_CUTOFF);
        queue_pixel('{8'h01, 8'h80, 8'h7F});
        queue_pixel('{8'hFE, 8'h01, 8'h80});
        queue_pixel('{8'h00, 8'h00, 8'h00});

        // tiny frame with the last column painted
        set_frame(3, 2, 65535, 2);
        repeat (3) queue_pixel('{8'hFF, 8'hFF, 8'hFF});
        repeat (3) queue_pixel('{8'h00, 8'h00, 8'h00});

        // size shrinks under a running frame
        set_frame(4, 4, 65535, 2047);
        queue_pixel('{8'h12, 8'h34, 8'h56});
        queue_pixel('{8'h9A, 8'hBC, 8'hDE});
        set_frame(1, 1, 65535, 2047);
        queue_pixel('{8'h80, 8'h80, 8'h80});
        queue_pixel('{8'h7F, 8'h7F, 8'h7F});

        // cutoff at column zero paints everything
        set_frame(5, 3, 0, 0);
        queue_pixel('{8'h33, 8'hCC, 8'h0F});
        queue_pixel('{8'hF0, 8'h3C, 8'hC3});

        // random phases, extremes first
        run_phase(1, 40, 65535, 2047, 120, 0);
        run_phase(2047, 2047, 0, 2047, 100, 0);
        run_phase(20, 10, 12000, 0, 80, 0);
        run_phase(24, 8, 12000, 18, 200, 80);
        while (pixels_queued < RANDOM_ITEMS - LAST_PHASE_ITEMS)
        begin
            w = $urandom_range(3, 40);
            thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(6000, 16000);
            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                              : $urandom_range(w / 2, w + 2);
            run_phase(w, $urandom_range(1, 12), thr, cut, $urandom_range(80, 220), 0);
        end
        idling_on = 1'b0;
        run_phase(16, 8, 12000, 13, LAST_PHASE_ITEMS, 0);

        drain();
        repeat (4) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", results_due.size()));
        $display("%0d pixels checked over many register settings, %0d frames closed",
                 results_seen, frames_closed);
        $display("results with a top-left corner: %0d, with a bottom-right corner: %0d",
                 top_hits, bottom_hits);
        if (mismatch_count == 0)
            $display("** dark_run_corner_finder: PASSED **");
        else
            $display("** dark_run_corner_finder: FAILED **");
        $finish;
    end

endmodule
